// ===== src/lcgrd_pkg.sv =====
// ---------------------------------------------------------------------------
// lcgrd_pkg: shared types and constants of the 48-bit LCG draw block
// Request and result words, draw kinds, generator constants and the widths
// of the shared multiplier.
// ---------------------------------------------------------------------------
`default_nettype none

package lcgrd_pkg;

    // generator
    localparam int unsigned LCG_BITS  = 48;
    localparam int unsigned MULT_BITS = 35;
    localparam logic [MULT_BITS-1:0] LCG_MULT = 35'd25214903917;
    localparam logic [LCG_BITS-1:0]  LCG_INC  = 48'd11;

    // fraction assembly: 26 bits from the first step, 27 from the second
    localparam int unsigned HI_BITS   = 26;
    localparam int unsigned LO_BITS   = 27;
    localparam int unsigned FRAC_BITS = 53;
    localparam int unsigned PROB_BITS = 54;

    // shared multiplier: A x B -> P
    localparam int unsigned MUL_A_W = 27;
    localparam int unsigned MUL_B_W = 33;
    localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

    // half of the state word used for partial products
    localparam int unsigned HALF_W = 24;

    // draw kinds
    localparam logic [1:0] KIND_FRAC = 2'd0;
    localparam logic [1:0] KIND_INT  = 2'd1;
    localparam logic [1:0] KIND_BOOL = 2'd2;

    typedef struct packed {
        logic [1:0]            kind;
        logic signed [31:0]    low_bound;
        logic signed [31:0]    high_bound;
        logic [PROB_BITS-1:0]  probability;
    } req_t;

    typedef struct packed {
        logic [FRAC_BITS-1:0]  fraction;
        logic signed [31:0]    int_value;
        logic                  bool_value;
        logic                  bad_range;
    } rsp_t;

    // top -> core control
    typedef struct packed {
        logic start;
        logic res_ready;
        logic seed_load;
    } core_ctl_t;

    // core -> top status
    typedef struct packed {
        logic idle;
        logic done;
    } core_sts_t;

endpackage

`default_nettype wire

// ===== src/lcgrd_mul.sv =====
// ---------------------------------------------------------------------------
// lcgrd_mul: shared registered multiplier
// Unsigned 27 x 33 product, registered; one result per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module lcgrd_mul (
    input  wire logic                         clk,
    input  wire logic [lcgrd_pkg::MUL_A_W-1:0] op_a,
    input  wire logic [lcgrd_pkg::MUL_B_W-1:0] op_b,
    output logic      [lcgrd_pkg::MUL_P_W-1:0] prod
);

    localparam int unsigned PW = lcgrd_pkg::MUL_P_W;

    logic [lcgrd_pkg::MUL_P_W-1:0] prod_reg;
    logic [lcgrd_pkg::MUL_P_W-1:0] prod_next;

    assign prod_next = PW'(op_a) * PW'(op_b);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// ===== src/lcgrd_core.sv =====
// ---------------------------------------------------------------------------
// lcgrd_core: draw sequencer
// Holds the generator state and steps it through the shared multiplier:
// three partial products per LCG step, two steps per draw, then two more
// products to scale the fraction for integer draws.
// ---------------------------------------------------------------------------
`default_nettype none

module lcgrd_core (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire lcgrd_pkg::core_ctl_t  ctl,
    input  wire lcgrd_pkg::req_t       req,
    input  wire logic [lcgrd_pkg::LCG_BITS-1:0] seed,
    output lcgrd_pkg::core_sts_t       sts,
    output lcgrd_pkg::rsp_t            res
);

    localparam int unsigned HW = lcgrd_pkg::HALF_W;
    localparam int unsigned LB = lcgrd_pkg::LCG_BITS;
    localparam int unsigned AW = lcgrd_pkg::MUL_A_W;
    localparam int unsigned BW = lcgrd_pkg::MUL_B_W;
    localparam int unsigned PW = lcgrd_pkg::MUL_P_W;
    localparam int unsigned FW = lcgrd_pkg::FRAC_BITS;
    localparam int unsigned HB = lcgrd_pkg::HI_BITS;
    localparam int unsigned LOB = lcgrd_pkg::LO_BITS;

    // sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_M0   = 4'd1;   // issue s_lo * m_lo
    localparam logic [3:0] S_M1   = 4'd2;   // acc = p + inc, issue s_lo * m_hi
    localparam logic [3:0] S_M2   = 4'd3;   // acc += p << 24, issue s_hi * m_lo
    localparam logic [3:0] S_M3   = 4'd4;   // new state = acc + p << 24
    localparam logic [3:0] S_S0   = 4'd5;   // issue frac_lo * range
    localparam logic [3:0] S_S1   = 4'd6;   // acc = p >> 27, issue frac_hi * range
    localparam logic [3:0] S_S2   = 4'd7;   // offset = (p + acc) >> 26
    localparam logic [3:0] S_FIN  = 4'd8;   // result ready

    localparam logic [HW-1:0]    M_LO = lcgrd_pkg::LCG_MULT[HW-1:0];
    localparam logic [10:0]      M_HI = lcgrd_pkg::LCG_MULT[lcgrd_pkg::MULT_BITS-1:HW];

    logic [3:0]   state_reg, state_next;
    logic         step_reg, step_next;
    logic [LB-1:0] lcg_reg, lcg_next;

    logic [1:0]   kind_reg, kind_next;
    logic [31:0]  low_reg, low_next;
    logic [32:0]  range_reg, range_next;
    logic [lcgrd_pkg::PROB_BITS-1:0] prob_reg, prob_next;
    logic [LB-1:0] acc_reg, acc_next;
    logic [FW-1:0] frac_reg, frac_next;
    logic [31:0]  ival_reg, ival_next;
    logic         bad_reg, bad_next;

    logic [AW-1:0] op_a;
    logic [BW-1:0] op_b;
    logic [PW-1:0] prod;

    logic [LB-1:0] step_sum;
    logic [PW-1:0] scale_sum;
    logic [31:0]   lo_flip, hi_flip;
    logic          start_bad;

    lcgrd_mul u_mul (
        .clk  (clk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    // operand select for the shared multiplier
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        case (state_reg)
            S_M0:
            begin
                op_a = AW'(lcg_reg[HW-1:0]);
                op_b = BW'(M_LO);
            end
            S_M1:
            begin
                op_a = AW'(lcg_reg[HW-1:0]);
                op_b = BW'(M_HI);
            end
            S_M2:
            begin
                op_a = AW'(lcg_reg[LB-1:HW]);
                op_b = BW'(M_LO);
            end
            S_S0:
            begin
                op_a = AW'(frac_reg[LOB-1:0]);
                op_b = range_reg;
            end
            S_S1:
            begin
                op_a = AW'(frac_reg[FW-1:LOB]);
                op_b = range_reg;
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // signed compare through sign-bit flip
    assign lo_flip   = req.low_bound  ^ 32'h8000_0000;
    assign hi_flip   = req.high_bound ^ 32'h8000_0000;
    assign start_bad = (req.kind == lcgrd_pkg::KIND_INT) && (lo_flip > hi_flip);

    // cross terms only contribute their low half above bit 24
    assign step_sum  = acc_reg + {prod[HW-1:0], {HW{1'b0}}};
    assign scale_sum = prod + PW'(acc_reg[32:0]);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        lcg_next   = lcg_reg;
        kind_next  = kind_reg;
        low_next   = low_reg;
        range_next = range_reg;
        prob_next  = prob_reg;
        acc_next   = acc_reg;
        frac_next  = frac_reg;
        ival_next  = ival_reg;
        bad_next   = bad_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (ctl.seed_load)
                begin
                    lcg_next = seed;
                end
                if (ctl.start)
                begin
                    kind_next  = req.kind;
                    low_next   = req.low_bound;
                    range_next = {1'b0, hi_flip} - {1'b0, lo_flip} + 33'd1;
                    prob_next  = req.probability;
                    frac_next  = '0;
                    ival_next  = '0;
                    bad_next   = start_bad;
                    step_next  = 1'b0;
                    if (start_bad || (req.kind != lcgrd_pkg::KIND_FRAC &&
                                      req.kind != lcgrd_pkg::KIND_INT &&
                                      req.kind != lcgrd_pkg::KIND_BOOL))
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        state_next = S_M0;
                    end
                end
            end
            S_M0:
            begin
                state_next = S_M1;
            end
            S_M1:
            begin
                acc_next   = prod[LB-1:0] + lcgrd_pkg::LCG_INC;
                state_next = S_M2;
            end
            S_M2:
            begin
                acc_next   = step_sum;
                state_next = S_M3;
            end
            S_M3:
            begin
                lcg_next = step_sum;
                if (!step_reg)
                begin
                    frac_next[FW-1:LOB] = step_sum[LB-1:LB-HB];
                    step_next  = 1'b1;
                    state_next = S_M0;
                end
                else
                begin
                    frac_next[LOB-1:0] = step_sum[LB-1:LB-LOB];
                    if (kind_reg == lcgrd_pkg::KIND_INT)
                    begin
                        state_next = S_S0;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_S0:
            begin
                state_next = S_S1;
            end
            S_S1:
            begin
                acc_next   = LB'(prod[PW-1:LOB]);
                state_next = S_S2;
            end
            S_S2:
            begin
                // offset < 2^32 since fraction < 2^53
                ival_next  = low_reg + scale_sum[HB+31:HB];
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (ctl.res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= 1'b0;
            lcg_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            lcg_reg   <= lcg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        low_reg   <= low_next;
        range_reg <= range_next;
        prob_reg  <= prob_next;
        acc_reg   <= acc_next;
        frac_reg  <= frac_next;
        ival_reg  <= ival_next;
        bad_reg   <= bad_next;
    end

    assign sts.idle = (state_reg == S_IDLE);
    assign sts.done = (state_reg == S_FIN);

    assign res.fraction   = frac_reg;
    assign res.int_value  = ival_reg;
    assign res.bool_value = (kind_reg == lcgrd_pkg::KIND_BOOL) &&
                            ({1'b0, frac_reg} < prob_reg);
    assign res.bad_range  = bad_reg;

    // generator state only moves at the end of a step or on a seed load
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_M3 && !(state_reg == S_IDLE && ctl.seed_load))
        |=> $stable(lcg_reg))
    else $error("lcg state changed outside a step");

    // a rejected range never carries a draw
    assert property (@(posedge clk) disable iff (!rst_n)
        (sts.done && res.bad_range) |-> (res.fraction == '0 && res.int_value == '0))
    else $error("bad range result carries data");

    // a finished result holds until the output side takes it
    assert property (@(posedge clk) disable iff (!rst_n)
        (sts.done && !ctl.res_ready) |=> (sts.done && $stable(frac_reg) && $stable(ival_reg)))
    else $error("result dropped while waiting");

    // a draw starts only from idle on a start request
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && !ctl.start) |=> (state_reg == S_IDLE))
    else $error("sequencer left idle without a request");

endmodule

`default_nettype wire

// ===== src/lcg48_random_draw.sv =====
// ---------------------------------------------------------------------------
// lcg48_random_draw: 48-bit LCG random draw block
// Fraction, bounded integer and Bernoulli draws from a seeded 48-bit LCG.
// ---------------------------------------------------------------------------
// The block keeps a 48-bit LCG state (x = x * 25214903917 + 11 mod 2^48),
// loaded directly by a write on the cfg port (no scrambling). Each draw steps
// the state twice and joins the top 26 and 27 bits into a 53-bit fraction.
// Kind 0 returns the fraction, kind 1 returns low_bound + floor(f*range/2^53)
// exactly, kind 2 returns fraction < probability. A kind 1 request with
// low_bound > high_bound returns bad_range with zero fields and leaves the
// state alone; kind 3 returns an all-zero word and leaves the state alone.
// Timing: one request word is in flight at a time. For kinds 0 and 2 the core
// steps through S_M0..S_M3 twice and then S_FIN; kind 1 adds S_S0..S_S2
// before S_FIN; a bad range or kind 3 goes straight to S_FIN. The result word
// is loaded into the output register from S_FIN once it is free, as the core
// returns to idle, and a new request is taken from idle.
// Draw length is set by the single shared 27x33 registered multiplier: each
// LCG step needs three partial products and the two steps of a draw are
// dependent; integer draws add two more products for the range scaling.
// The output register lets the next request start while a result waits.
// Seed writes are taken only while the sequencer is idle (cfg_ready).
// ---------------------------------------------------------------------------
`default_nettype none

module lcg48_random_draw (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // request channel
    input  wire logic                                req_valid,
    output logic                                     req_stall,
    input  wire lcgrd_pkg::req_t                     req_word,
    // result channel
    output logic                                     rsp_valid,
    input  wire logic                                rsp_stall,
    output lcgrd_pkg::rsp_t                          rsp_word,
    // seed write channel
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [lcgrd_pkg::LCG_BITS-1:0]      cfg_data
);

    lcgrd_pkg::core_ctl_t ctl;
    lcgrd_pkg::core_sts_t sts;
    lcgrd_pkg::rsp_t      core_res;

    logic            rsp_valid_reg, rsp_valid_next;
    lcgrd_pkg::rsp_t rsp_word_reg, rsp_word_next;
    logic            out_free;

    // output register is free when empty or being taken this cycle
    assign out_free = !rsp_valid_reg || !rsp_stall;

    assign req_stall = !sts.idle;
    assign cfg_ready = sts.idle;

    assign ctl.start     = req_valid && sts.idle;
    assign ctl.res_ready = out_free;
    assign ctl.seed_load = cfg_valid && sts.idle;

    lcgrd_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .req   (req_word),
        .seed  (cfg_data),
        .sts   (sts),
        .res   (core_res)
    );

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_word_next  = rsp_word_reg;
        if (sts.done && out_free)
        begin
            rsp_valid_next = 1'b1;
            rsp_word_next  = core_res;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_word_reg <= rsp_word_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

endmodule

`default_nettype wire

// ===== bench/tb_lcg48_random_draw.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_lcg48_random_draw: self-checking bench for the 48-bit LCG draw block
// Drives request words from a queue and keeps its own copy of the generator.
// Each accepted request is turned into an expected result word, and each
// accepted result word is checked field by field against the oldest one.
// Phases vary the seed and the idle and stall rates on both channels.
// ---------------------------------------------------------------------------

module tb_lcg48_random_draw;

    localparam int CLK_HALF      = 6;       // 12 ns period
    localparam int RESET_CYCLES  = 8;
    localparam int PHASE_ITEMS   = 290;     // six random phases, ~1750 words
    localparam int RANDOM_PHASES = 6;
    localparam int SETTLE_CYCLES = 40;      // well past the longest unstalled draw
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PRINT_CAP     = 50;

    localparam int unsigned LCG_BITS  = lcgrd_pkg::LCG_BITS;
    localparam int unsigned PROB_BITS = lcgrd_pkg::PROB_BITS;
    localparam int unsigned FRAC_BITS = lcgrd_pkg::FRAC_BITS;
    localparam int unsigned HI_BITS   = lcgrd_pkg::HI_BITS;
    localparam int unsigned LO_BITS   = lcgrd_pkg::LO_BITS;

    // kind code the block treats as a no-op (one all-zero result)
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam logic signed [31:0] I32_MIN  = 32'sh8000_0000;
    localparam logic signed [31:0] I32_MAX  = 32'sh7FFF_FFFF;
    localparam logic [PROB_BITS-1:0] PROB_ONE = 54'd1 << FRAC_BITS;
    localparam logic [PROB_BITS-1:0] PROB_ALL = '1;
    localparam logic [LCG_BITS-1:0]  SEED_ALL_ONES = '1;

    // DUT connections; every input known from time zero
    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_stall;
    lcgrd_pkg::req_t     req_word  = '0;
    logic                rsp_valid;
    logic                rsp_stall = 1'b0;
    lcgrd_pkg::rsp_t     rsp_word;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [LCG_BITS-1:0] cfg_data = '0;

    // bench-side generator state, updated on seed writes and accepted draws
    logic [LCG_BITS-1:0] gen_state = '0;

    lcgrd_pkg::req_t queued_reqs[$];    // request words waiting for the driver
    lcgrd_pkg::rsp_t pending_draws[$];  // expected result words, oldest first

    int  idle_pct       = 0;    // chance the sender holds off per cycle
    int  stall_pct      = 0;    // chance the receiver stalls per cycle
    bit  req_taken      = 1'b0; // request handshake seen at the last rising edge
    int  mismatch_count = 0;
    int  result_count   = 0;
    int  cycle_count    = 0;

    lcg48_random_draw u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_word  (req_word),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #(CLK_HALF) clk = ~clk;

    // -----------------------------------------------------------------------
    // Generator model
    // -----------------------------------------------------------------------

    // One LCG step; the 48-bit context makes the product wrap mod 2^48.
    function automatic logic [LCG_BITS-1:0] lcg_next(input logic [LCG_BITS-1:0] s);
        logic [LCG_BITS-1:0] mult;
        mult = LCG_BITS'(lcgrd_pkg::LCG_MULT);
        return s * mult + lcgrd_pkg::LCG_INC;
    endfunction

    // Two steps: top 26 bits of the first, top 27 of the second.
    function automatic logic [FRAC_BITS-1:0] draw_fraction();
        logic [LCG_BITS-1:0] first_step;
        first_step = lcg_next(gen_state);
        gen_state  = lcg_next(first_step);
        return {first_step[LCG_BITS-1 -: HI_BITS],
                gen_state[LCG_BITS-1 -: LO_BITS]};
    endfunction

    // Expected result word for one accepted request; advances gen_state.
    function automatic lcgrd_pkg::rsp_t predict_draw(input lcgrd_pkg::req_t r);
        lcgrd_pkg::rsp_t o;
        logic [31:0]     low_biased;
        logic [31:0]     high_biased;
        logic [32:0]     span;
        logic [85:0]     scaled;
        o = '0;
        case (r.kind)
            lcgrd_pkg::KIND_FRAC: o.fraction = draw_fraction();
            lcgrd_pkg::KIND_INT:
            begin
                // flip the sign bits so an unsigned compare orders signed values
                low_biased  = {~r.low_bound[31], r.low_bound[30:0]};
                high_biased = {~r.high_bound[31], r.high_bound[30:0]};
                if (low_biased > high_biased)
                begin
                    o.bad_range = 1'b1;     // state holds, other fields zero
                end
                else
                begin
                    span       = {1'b0, high_biased - low_biased} + 33'd1;
                    o.fraction = draw_fraction();
                    // exact floor(f * span / 2^53); the offset is below span
                    scaled      = o.fraction * span;
                    o.int_value = r.low_bound + scaled[84:53];
                end
            end
            lcgrd_pkg::KIND_BOOL:
            begin
                o.fraction   = draw_fraction();
                o.bool_value = ({1'b0, o.fraction} < r.probability);
            end
            default: ;  // unused kind: all-zero word, state holds
        endcase
        return o;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("%0t ns: result %0d %s: got %0h, expected %0h",
                     $time, result_count, what, got, want);
    endtask

    // -----------------------------------------------------------------------
    // Rising edge: handshakes, prediction, checking and the timeout
    // -----------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        lcgrd_pkg::rsp_t want;
        if (rst_n)
        begin
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
            else
            begin
                req_taken = req_valid && !req_stall;
                if (cfg_valid && cfg_ready)
                    gen_state = cfg_data;   // a seed write loads the state as is
                // check the result before queuing this edge's prediction
                if (rsp_valid && !rsp_stall)
                begin
                    result_count++;
                    if (pending_draws.size() == 0)
                    begin
                        report_mismatch("arrived with nothing pending",
                                        64'(rsp_word.fraction), 64'd0);
                    end
                    else
                    begin
                        want = pending_draws.pop_front();
                        if (rsp_word.fraction !== want.fraction)
                            report_mismatch("fraction", 64'(rsp_word.fraction),
                                            64'(want.fraction));
                        if (rsp_word.int_value !== want.int_value)
                            report_mismatch("int_value", {32'd0, rsp_word.int_value},
                                            {32'd0, want.int_value});
                        if (rsp_word.bool_value !== want.bool_value)
                            report_mismatch("bool_value", {63'd0, rsp_word.bool_value},
                                            {63'd0, want.bool_value});
                        if (rsp_word.bad_range !== want.bad_range)
                            report_mismatch("bad_range", {63'd0, rsp_word.bad_range},
                                            {63'd0, want.bad_range});
                    end
                end
                if (req_taken)
                    pending_draws.push_back(predict_draw(req_word));
            end
        end
    end

    // -----------------------------------------------------------------------
    // Falling edge: request driver and result stall
    // A word stays put until taken; only then may the sender go idle or
    // present the next word from the queue.
    // -----------------------------------------------------------------------
    always @(negedge clk)
    begin : driver
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            rsp_stall <= 1'b0;
        end
        else
        begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
            if (!req_valid || req_taken)
            begin
                if (queued_reqs.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    req_word  <= queued_reqs.pop_front();
                    req_valid <= 1'b1;
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // Stimulus helpers
    // -----------------------------------------------------------------------

    function automatic lcgrd_pkg::req_t make_req(input logic [1:0] kind,
                                                 input logic signed [31:0] lo,
                                                 input logic signed [31:0] hi,
                                                 input logic [PROB_BITS-1:0] prob);
        lcgrd_pkg::req_t r;
        r.kind        = kind;
        r.low_bound   = lo;
        r.high_bound  = hi;
        r.probability = prob;
        return r;
    endfunction

    // Mostly well-formed draws; fields a kind ignores stay random.
    function automatic lcgrd_pkg::req_t random_req();
        lcgrd_pkg::req_t    r;
        int                 pick;
        logic signed [31:0] swap;
        r.low_bound   = $urandom;
        r.high_bound  = $urandom;
        r.probability = PROB_BITS'({$urandom, $urandom});
        pick = $urandom_range(99);
        if (pick < 30)
            r.kind = lcgrd_pkg::KIND_FRAC;
        else if (pick < 65)
            r.kind = lcgrd_pkg::KIND_INT;
        else if (pick < 95)
            r.kind = lcgrd_pkg::KIND_BOOL;
        else
            r.kind = KIND_UNUSED;

        if (r.kind == lcgrd_pkg::KIND_INT)
        begin
            case ($urandom_range(5))
                0: ;    // raw bounds, mostly ordered below
                1: ;    // raw bounds, mostly ordered below
                2: r.high_bound = r.low_bound + $urandom_range(15);
                3:
                begin
                    case ($urandom_range(3))
                        0: r.low_bound = I32_MIN;
                        1: r.low_bound = I32_MIN + 1;
                        2: r.low_bound = -1;
                        default: r.low_bound = 0;
                    endcase
                    r.high_bound = $urandom_range(1) ? I32_MAX : r.low_bound;
                end
                4:
                begin
                    r.low_bound  = I32_MIN;
                    r.high_bound = I32_MAX;
                end
                default: r.high_bound = r.low_bound + ((32'd1 << $urandom_range(31)) - 1);
            endcase
            // wrap-around on the small spans counts as a bad range otherwise
            if (r.high_bound < r.low_bound && $urandom_range(7) != 0)
            begin
                swap         = r.low_bound;
                r.low_bound  = r.high_bound;
                r.high_bound = swap;
            end
        end
        else if (r.kind == lcgrd_pkg::KIND_BOOL)
        begin
            case ($urandom_range(7))
                5: ;                                        // may exceed one
                6: r.probability = $urandom_range(1) ? PROB_ONE : '0;
                7: r.probability = PROB_BITS'(r.probability[39:0]); // small odds
                default: r.probability[PROB_BITS-1] = 1'b0; // within [0, 1)
            endcase
        end
        return r;
    endfunction

    // Returns at a falling edge with nothing queued, in flight or pending.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (queued_reqs.size() != 0 || req_valid || pending_draws.size() != 0);
    endtask

    // Seed write; only issued while the block has nothing in flight.
    task automatic load_seed(input logic [LCG_BITS-1:0] seed);
        cfg_valid <= 1'b1;
        cfg_data  <= seed;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // One phase of random words; optionally the sender stops halfway until
    // every expected result word is back.
    task automatic run_phase(input int count, input int idle, input int stall,
                             input bit pause_midway);
        idle_pct  = idle;
        stall_pct = stall;
        for (int i = 0; i < count; i++)
        begin
            if (pause_midway && i == count / 2)
                wait_drained();
            queued_reqs.push_back(random_req());
        end
        wait_drained();
    endtask

    // -----------------------------------------------------------------------
    // Test sequence
    // -----------------------------------------------------------------------
    initial
    begin : stimulus
        logic [LCG_BITS-1:0] next_seed;
        int                  idle;
        int                  stall;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // directed words from the reset state (seed zero), no idling
        queued_reqs.push_back(make_req(lcgrd_pkg::KIND_FRAC, 0, 0, '0));
        queued_reqs.push_back(make_req(lcgrd_pkg::KIND_FRAC, -1, -1, PROB_ALL));
        // full 32-bit span, single-value spans at both ends, mixed signs
        queued_reqs.push_back(make_req(lcgrd_pkg::KIND_INT, I32_MIN, I32_MAX, '0));
        queued_reqs.push_back(make_req(lcgrd_pkg::KIND_INT, I32_MAX, I32_MAX, '0));
        queued_reqs.push_back(make_req(lcgrd_pkg::KIND_INT, I32_MIN, I32_MIN, '0));
        queued_reqs.push_back(make_req(lcgrd_pkg::KIND_INT, 0, 0, '0));
        queued_reqs.push_back(make_req(lcgrd_pkg::KIND_INT, -5, 5, PROB_ALL));
        queued_reqs.push_back(make_req(lcgrd_pkg::KIND_INT, I32_MIN, I32_MIN + 1, '0));
        queued_reqs.push_back(make_req(lcgrd_pkg::KIND_INT, -1, 0, '0));
        // inverted bounds: bad range, state holds
        queued_reqs.push_back(make_req(lcgrd_pkg::KIND_INT, I32_MAX, I32_MIN, '0));
        queued_reqs.push_back(make_req(lcgrd_pkg::KIND_INT, 1, 0, '0));
        queued_reqs.push_back(make_req(lcgrd_pkg::KIND_INT, 0, -1, PROB_ALL));
        // probability at zero, the smallest step, one, just around one, and above one
        queued_reqs.push_back(make_req(lcgrd_pkg::KIND_BOOL, 0, 0, '0));
        queued_reqs.push_back(make_req(lcgrd_pkg::KIND_BOOL, 0, 0, 54'd1));
        queued_reqs.push_back(make_req(lcgrd_pkg::KIND_BOOL, 0, 0, PROB_ONE - 1));
        queued_reqs.push_back(make_req(lcgrd_pkg::KIND_BOOL, 0, 0, PROB_ONE));
        queued_reqs.push_back(make_req(lcgrd_pkg::KIND_BOOL, 0, 0, PROB_ONE + 1));
        queued_reqs.push_back(make_req(lcgrd_pkg::KIND_BOOL, -1, -1, PROB_ALL));
        // unused kind with quiet and busy fields
        queued_reqs.push_back(make_req(KIND_UNUSED, 0, 0, '0));
        queued_reqs.push_back(make_req(KIND_UNUSED, -1, -1, PROB_ALL));
        wait_drained();

        // random phases, each behind a fresh seed
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0: next_seed = SEED_ALL_ONES;
                2: next_seed = '0;
                4: next_seed = 48'd1;
                default: next_seed = LCG_BITS'({$urandom, $urandom});
            endcase
            case (p)
                1: begin idle = 60; stall = 0;  end
                2: begin idle = 0;  stall = 60; end
                3: begin idle = 6;  stall = 6;  end
                4: begin idle = 60; stall = 60; end
                default: begin idle = 0; stall = 0; end
            endcase
            load_seed(next_seed);
            run_phase(PHASE_ITEMS, idle, stall, p == 1);
        end

        // let any stray result word show up before the verdict
        stall_pct = 0;
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (mismatch_count == 0 && pending_draws.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== files.f =====
src/lcgrd_pkg.sv
src/lcgrd_mul.sv
src/lcgrd_core.sv
src/lcg48_random_draw.sv
bench/tb_lcg48_random_draw.sv
